// ----- hdl/pd_pkg.sv -----
// ---------------------------------------------------------------------------
// pd_pkg
// Shared types, codes and constants of the packet deframer with CRC-16 check.
// ---------------------------------------------------------------------------
package pd_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_PAYLOAD_DEF = 28;
  localparam int NUM_TYPES_DEF   = 4;

  // Frame layout: type and length bytes ahead of the payload, two CRC bytes after it.
  localparam int HDR_BYTES = 2;
  localparam int OVERHEAD  = 4;

  // Bits folded into the CRC per received byte.
  localparam int CRC_BITS = 8;

  // Configuration port geometry.
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  // Register reset values.
  localparam logic [15:0] CRC_POLY_RST = 16'h1021;
  localparam logic [15:0] CRC_INIT_RST = 16'hFFFF;
  localparam logic [3:0]  TYPE_MASK_RST = 4'hF;

  typedef enum logic [CFG_IW-1:0] {
    REG_LEN0 = 3'd0,
    REG_LEN1 = 3'd1,
    REG_LEN2 = 3'd2,
    REG_LEN3 = 3'd3,
    REG_POLY = 3'd4,
    REG_INIT = 3'd5,
    REG_MASK = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EV_PAYLOAD      = 2'd0,
    EV_BAD_TYPE     = 2'd1,
    EV_LEN_MISMATCH = 2'd2,
    EV_CRC_FAIL     = 2'd3
  } ev_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_CHECK,
    ST_EVENT,
    ST_READ,
    ST_EMIT
  } state_t;

  // Command to the shared CRC unit: start an eight step run from seed.
  typedef struct packed {
    logic        start;
    logic [15:0] seed;
  } crc_cmd_t;

  // Status of the shared CRC unit.
  typedef struct packed {
    logic        busy;
    logic [15:0] crc;
  } crc_sts_t;

endpackage

// ----- hdl/pd_in_if.sv -----
// ---------------------------------------------------------------------------
// pd_in_if
// Received byte channel with valid/ready handshake.
// ---------------------------------------------------------------------------
interface pd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- hdl/pd_out_if.sv -----
// ---------------------------------------------------------------------------
// pd_out_if
// Result channel of the deframer with valid/ready handshake.
// ---------------------------------------------------------------------------
interface pd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] frame_type;
  logic [7:0] payload_byte;
  logic [5:0] byte_index;
  logic       last;

  modport source (output valid, output event_res, output frame_type, output payload_byte,
                  output byte_index, output last, input ready);
  modport sink   (input valid, input event_res, input frame_type, input payload_byte,
                  input byte_index, input last, output ready);
endinterface

// ----- hdl/pd_crc_unit.sv -----
// ---------------------------------------------------------------------------
// pd_crc_unit
// Bit-serial CRC-16 engine: one polynomial step per clock, eight per byte.
// ---------------------------------------------------------------------------
module pd_crc_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  pd_pkg::crc_cmd_t   cmd,
  input  logic [15:0]        poly,
  output pd_pkg::crc_sts_t   sts
);

  localparam int CW = $clog2(pd_pkg::CRC_BITS);

  logic [15:0]   crc_r, crc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [15:0]   shifted;

  assign shifted = {crc_r[14:0], 1'b0};

  always_comb begin
    crc_nxt  = crc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (cmd.start) begin
      crc_nxt  = cmd.seed;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      crc_nxt = crc_r[15] ? (shifted ^ poly) : shifted;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(pd_pkg::CRC_BITS - 1)) begin
        busy_nxt = 1'b0;
        cnt_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= pd_pkg::CRC_INIT_RST;
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      crc_r  <= crc_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.crc  = crc_r;

  // A new run is only requested once the previous one has finished.
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r) else $error("CRC start while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> busy_r) else $error("CRC run did not begin");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (cnt_r == '0)) else $error("CRC step count not cleared");

endmodule

// ----- hdl/pd_frame_mem.sv -----
// ---------------------------------------------------------------------------
// pd_frame_mem
// Frame byte store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module pd_frame_mem #(
  parameter int DEPTH = pd_pkg::MAX_PAYLOAD_DEF + pd_pkg::OVERHEAD
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/packet_deframer_crc16.sv -----
// ---------------------------------------------------------------------------
// packet_deframer_crc16
// Type/length/payload/CRC-16 deframer: checks each frame and emits payload.
// ---------------------------------------------------------------------------
// Each frame byte is accepted, folded in by eight steps of the shared bit-serial
// CRC unit, and the sequencer sees the unit finish before it takes the next byte.
// A byte dropped without opening a frame passes through the event state per beat.
// At frame end the check state follows, then each payload beat is a frame store
// read and then an output load, which waits while the output side stalls.
// Reset is synchronous and active low and restarts the frame; the store is not cleared.
module packet_deframer_crc16 #(
  parameter int MAX_PAYLOAD = pd_pkg::MAX_PAYLOAD_DEF,
  parameter int NUM_TYPES   = pd_pkg::NUM_TYPES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  pd_in_if.sink                     in_bus,
  pd_out_if.source                  out_bus,
  input  logic                      cfg_we,
  input  logic [pd_pkg::CFG_IW-1:0] cfg_index,
  input  logic [pd_pkg::CFG_DW-1:0] cfg_wdata
);

  // The store holds a whole frame: header, payload and CRC bytes.
  localparam int STORE_DEPTH = MAX_PAYLOAD + pd_pkg::OVERHEAD;
  localparam int AW = $clog2(STORE_DEPTH);
  // Expected length and the incremented fill count can both reach the store depth.
  localparam int LW = $clog2(STORE_DEPTH + 1);

  // Configuration registers.
  logic [7:0]  len_r [4];
  logic [15:0] crc_poly_r;
  logic [15:0] crc_init_r;
  logic [3:0]  type_mask_r;

  // Sequencer and frame state.
  pd_pkg::state_t state_r, state_nxt;
  logic [LW-1:0]  fill_r, fill_nxt;
  logic [LW-1:0]  exp_r, exp_nxt;
  logic [7:0]     type_r, type_nxt;
  logic [7:0]     byte_r, byte_nxt;
  logic           check_pend_r, check_pend_nxt;
  logic           crc_pend_r, crc_pend_nxt;
  logic           ev2nd_r, ev2nd_nxt;
  pd_pkg::ev_t    ev_code_r, ev_code_nxt;
  logic [7:0]     ev_type_r, ev_type_nxt;
  logic           ev_last_r, ev_last_nxt;
  logic [5:0]     idx_r, idx_nxt;

  // Output register.
  logic           out_valid_r, out_valid_nxt;
  pd_pkg::ev_t    out_event_r, out_event_nxt;
  logic [7:0]     out_type_r, out_type_nxt;
  logic [7:0]     out_data_r, out_data_nxt;
  logic [5:0]     out_idx_r, out_idx_nxt;
  logic           out_last_r, out_last_nxt;

  // Shared CRC unit and frame store.
  pd_pkg::crc_cmd_t crc_cmd;
  pd_pkg::crc_sts_t crc_sts;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [7:0]       mem_rdata;

  // Decode of the incoming byte.
  logic       in_fire;
  logic [7:0] rx;
  logic [7:0] sel_len;
  logic       type_ok;
  logic       len_match;
  logic       at_start;
  logic       at_length;
  logic       do_start;
  logic       do_event;
  logic       do_body;
  logic [LW-1:0] fill_inc;
  logic       frame_done;
  logic       out_free;
  logic       last_pay;
  logic       type_enabled;

  assign in_bus.ready = (state_r == pd_pkg::ST_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign rx           = in_bus.rx_byte;

  // A type byte is good when it names a known type whose payload length is
  // between one and the maximum payload.
  assign sel_len   = len_r[rx[1:0]];
  assign type_ok   = (rx < 8'(NUM_TYPES)) && (sel_len != 8'd0) &&
                     (sel_len <= 8'(MAX_PAYLOAD));
  assign len_match = (rx == 8'(exp_r));
  assign at_start  = (fill_r == LW'(0));
  assign at_length = (fill_r == LW'(1));

  // Every accepted byte either starts a frame, drops something, or continues
  // the frame body. A length mismatch both drops the old type byte and may
  // start a new frame with the byte just received.
  assign do_start = in_fire && (at_start || (at_length && !len_match)) && type_ok;
  assign do_event = in_fire && ((at_start && !type_ok) || (at_length && !len_match));
  assign do_body  = in_fire && !at_start && !(at_length && !len_match);

  assign fill_inc   = fill_r + 1'b1;
  assign frame_done = (fill_inc >= exp_r);

  // The output register can take a beat when empty or being drained.
  assign out_free = !out_valid_r || out_bus.ready;

  // The final payload beat is the one whose index is the payload length less one.
  assign last_pay     = ((7'(idx_r) + 7'(pd_pkg::OVERHEAD + 1)) == 7'(exp_r));
  assign type_enabled = type_mask_r[type_r[1:0]];

  assign crc_cmd.start = do_start || do_body;
  assign crc_cmd.seed  = (do_start ? crc_init_r : crc_sts.crc) ^ {rx, 8'h00};

  assign mem_we    = do_body;
  assign mem_waddr = fill_r[AW-1:0];
  assign mem_re    = (state_r == pd_pkg::ST_READ);
  assign mem_raddr = AW'(7'(idx_r) + 7'(pd_pkg::HDR_BYTES));

  pd_crc_unit u_crc (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (crc_cmd),
    .poly (crc_poly_r),
    .sts  (crc_sts)
  );

  pd_frame_mem #(
    .DEPTH(STORE_DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(rx),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pd_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = do_event ? pd_pkg::ST_EVENT : pd_pkg::ST_CRC;
        end
      end
      pd_pkg::ST_CRC: begin
        if (!crc_sts.busy) begin
          state_nxt = check_pend_r ? pd_pkg::ST_CHECK : pd_pkg::ST_IDLE;
        end
      end
      pd_pkg::ST_CHECK: begin
        if (crc_sts.crc != 16'h0000) begin
          state_nxt = pd_pkg::ST_EVENT;
        end else if (type_enabled) begin
          state_nxt = pd_pkg::ST_READ;
        end else begin
          state_nxt = pd_pkg::ST_IDLE;
        end
      end
      pd_pkg::ST_EVENT: begin
        if (out_free) begin
          if (ev2nd_r) begin
            state_nxt = pd_pkg::ST_EVENT;
          end else if (crc_pend_r) begin
            state_nxt = pd_pkg::ST_CRC;
          end else begin
            state_nxt = pd_pkg::ST_IDLE;
          end
        end
      end
      pd_pkg::ST_READ: begin
        state_nxt = pd_pkg::ST_EMIT;
      end
      pd_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = last_pay ? pd_pkg::ST_IDLE : pd_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = pd_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    fill_nxt       = fill_r;
    exp_nxt        = exp_r;
    type_nxt       = type_r;
    byte_nxt       = byte_r;
    check_pend_nxt = check_pend_r;
    crc_pend_nxt   = crc_pend_r;
    ev2nd_nxt      = ev2nd_r;
    ev_code_nxt    = ev_code_r;
    ev_type_nxt    = ev_type_r;
    ev_last_nxt    = ev_last_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_bus.ready ? 1'b0 : out_valid_r;
    out_event_nxt  = out_event_r;
    out_type_nxt   = out_type_r;
    out_data_nxt   = out_data_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      pd_pkg::ST_IDLE: begin
        if (in_fire) begin
          byte_nxt       = rx;
          check_pend_nxt = 1'b0;
          crc_pend_nxt   = do_start;
          ev2nd_nxt      = 1'b0;
          if (do_start) begin
            type_nxt = rx;
            exp_nxt  = LW'(sel_len) + LW'(pd_pkg::OVERHEAD);
            fill_nxt = LW'(1);
          end
          if (do_event) begin
            if (at_start) begin
              // Bad type at frame start: drop the byte.
              ev_code_nxt = pd_pkg::EV_BAD_TYPE;
              ev_type_nxt = rx;
              ev_last_nxt = 1'b1;
              fill_nxt    = LW'(0);
            end else begin
              // Length mismatch: drop the old type byte; the byte just
              // received is retried as a type, and if it is bad too a
              // second event follows.
              ev_code_nxt = pd_pkg::EV_LEN_MISMATCH;
              ev_type_nxt = type_r;
              ev_last_nxt = type_ok;
              ev2nd_nxt   = !type_ok;
              if (!type_ok) begin
                fill_nxt = LW'(0);
              end
            end
          end
          if (do_body) begin
            fill_nxt       = frame_done ? LW'(0) : fill_inc;
            check_pend_nxt = frame_done;
          end
        end
      end
      pd_pkg::ST_CHECK: begin
        if (crc_sts.crc != 16'h0000) begin
          ev_code_nxt  = pd_pkg::EV_CRC_FAIL;
          ev_type_nxt  = type_r;
          ev_last_nxt  = 1'b1;
          ev2nd_nxt    = 1'b0;
          crc_pend_nxt = 1'b0;
        end
        idx_nxt = '0;
      end
      pd_pkg::ST_EVENT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_event_nxt = ev_code_r;
          out_type_nxt  = ev_type_r;
          out_data_nxt  = 8'h00;
          out_idx_nxt   = '0;
          out_last_nxt  = ev_last_r;
          if (ev2nd_r) begin
            ev_code_nxt = pd_pkg::EV_BAD_TYPE;
            ev_type_nxt = byte_r;
            ev_last_nxt = 1'b1;
            ev2nd_nxt   = 1'b0;
          end
        end
      end
      pd_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_event_nxt = pd_pkg::EV_PAYLOAD;
          out_type_nxt  = type_r;
          out_data_nxt  = mem_rdata;
          out_idx_nxt   = idx_r;
          out_last_nxt  = last_pay;
          idx_nxt       = idx_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pd_pkg::ST_IDLE;
      fill_r       <= '0;
      exp_r        <= '0;
      check_pend_r <= 1'b0;
      crc_pend_r   <= 1'b0;
      ev2nd_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      exp_r        <= exp_nxt;
      check_pend_r <= check_pend_nxt;
      crc_pend_r   <= crc_pend_nxt;
      ev2nd_r      <= ev2nd_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    type_r      <= type_nxt;
    byte_r      <= byte_nxt;
    ev_code_r   <= ev_code_nxt;
    ev_type_r   <= ev_type_nxt;
    ev_last_r   <= ev_last_nxt;
    idx_r       <= idx_nxt;
    out_event_r <= out_event_nxt;
    out_type_r  <= out_type_nxt;
    out_data_r  <= out_data_nxt;
    out_idx_r   <= out_idx_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Configuration registers; writes to an unused index are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r[0]    <= 8'd0;
      len_r[1]    <= 8'd0;
      len_r[2]    <= 8'd0;
      len_r[3]    <= 8'd0;
      crc_poly_r  <= pd_pkg::CRC_POLY_RST;
      crc_init_r  <= pd_pkg::CRC_INIT_RST;
      type_mask_r <= pd_pkg::TYPE_MASK_RST;
    end else if (cfg_we) begin
      case (pd_pkg::cfg_idx_t'(cfg_index))
        pd_pkg::REG_LEN0: len_r[0]    <= cfg_wdata[7:0];
        pd_pkg::REG_LEN1: len_r[1]    <= cfg_wdata[7:0];
        pd_pkg::REG_LEN2: len_r[2]    <= cfg_wdata[7:0];
        pd_pkg::REG_LEN3: len_r[3]    <= cfg_wdata[7:0];
        pd_pkg::REG_POLY: crc_poly_r  <= cfg_wdata;
        pd_pkg::REG_INIT: crc_init_r  <= cfg_wdata;
        pd_pkg::REG_MASK: type_mask_r <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.event_res    = out_event_r;
  assign out_bus.frame_type   = out_type_r;
  assign out_bus.payload_byte = out_data_r;
  assign out_bus.byte_index   = out_idx_r;
  assign out_bus.last         = out_last_r;

  // While a frame is open, the bytes held stay below the expected length.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != LW'(0)) |-> (fill_r < exp_r)) else $error("fill count past frame length");

  // The CRC unit has always finished by the time a new byte can be taken.
  a_crc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pd_pkg::ST_IDLE) |-> !crc_sts.busy) else $error("CRC busy while idle");

  // Payload beats never index past the largest payload.
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_event_r == pd_pkg::EV_PAYLOAD)) |->
      (7'(out_idx_r) < 7'(MAX_PAYLOAD))) else $error("payload index out of range");

  // The frame check only follows a finished CRC run.
  a_check_after_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pd_pkg::ST_CHECK) |-> ($past(state_r) == pd_pkg::ST_CRC) && !crc_sts.busy)
    else $error("frame check without finished CRC");

endmodule

// ----- test/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the type/length/CRC-16 packet deframer. Bytes are
// pushed through the input channel under random gaps while a byte-level
// predictor keeps its own frame buffer, CRC and register copy, and every
// output beat is compared field by field with the oldest predicted beat.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Bytes of frame the predictor can hold: header, largest payload, CRC.
  localparam int STORE_DEPTH = pd_pkg::MAX_PAYLOAD_DEF + pd_pkg::OVERHEAD;

  // Register index that names no register; writes to it must be ignored.
  localparam logic [pd_pkg::CFG_IW-1:0] REG_UNUSED = 3'd7;

  // Cycles allowed for the block to finish a byte that causes no beat.
  localparam int SETTLE_CYCLES = 40;

  // Hard stop for the whole run, far above the slowest legal run.
  localparam int CYCLE_LIMIT = 400000;

  // One result beat as the output channel carries it.
  typedef struct {
    pd_pkg::ev_t ev;
    logic [7:0]  ty;
    logic [7:0]  data;
    logic [5:0]  idx;
    logic        last;
  } result_beat_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pd_pkg::CFG_IW-1:0] cfg_index;
  logic [pd_pkg::CFG_DW-1:0] cfg_wdata;

  pd_in_if  in_bus ();
  pd_out_if out_bus ();

  packet_deframer_crc16 dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Register copy held by the predictor.
  logic [7:0]  len_tab [4];
  logic [15:0] poly_r;
  logic [15:0] init_r;
  logic [3:0]  mask_r;

  // Frame state held by the predictor.
  logic [7:0]  frame_buf [STORE_DEPTH];
  int unsigned got;
  int unsigned want;
  logic [15:0] crc_acc;

  // Beats predicted for the byte being processed, then the store of all
  // beats still owed by the block, oldest first.
  result_beat_t fresh_beats[$];
  result_beat_t expected_beats[$];

  int  errors;
  int  cycles;
  int  items_sent;
  bit  calm;

  // -------------------------------------------------------------------------
  // Clock and run limit.
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The counter runs in its own process; if the run has not wrapped up by
  // the limit, something is stuck and the run is declared broken.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d beats still expected", cycles,
             expected_beats.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Predictor.
  // -------------------------------------------------------------------------

  // One byte folded into an MSB-first CRC with no reflection.
  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b,
                                           logic [15:0] poly);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ poly) : (r << 1);
    end
    return r;
  endfunction

  function automatic void note(pd_pkg::ev_t ev, logic [7:0] ty, logic [7:0] data,
                               logic [5:0] idx);
    result_beat_t rb;
    rb.ev   = ev;
    rb.ty   = ty;
    rb.data = data;
    rb.idx  = idx;
    rb.last = 1'b0;
    fresh_beats.push_back(rb);
  endfunction

  function automatic void model_reset();
    foreach (len_tab[i]) len_tab[i] = 8'd0;
    poly_r  = pd_pkg::CRC_POLY_RST;
    init_r  = pd_pkg::CRC_INIT_RST;
    mask_r  = pd_pkg::TYPE_MASK_RST;
    foreach (frame_buf[i]) frame_buf[i] = 8'd0;
    got     = 0;
    want    = 0;
    crc_acc = pd_pkg::CRC_INIT_RST;
  endfunction

  // Register writes are masked to the width of the register they hit.
  function automatic void model_write(logic [pd_pkg::CFG_IW-1:0] idx,
                                      logic [pd_pkg::CFG_DW-1:0] v);
    case (idx)
      pd_pkg::REG_LEN0: len_tab[0] = v[7:0];
      pd_pkg::REG_LEN1: len_tab[1] = v[7:0];
      pd_pkg::REG_LEN2: len_tab[2] = v[7:0];
      pd_pkg::REG_LEN3: len_tab[3] = v[7:0];
      pd_pkg::REG_POLY: poly_r = v;
      pd_pkg::REG_INIT: init_r = v;
      pd_pkg::REG_MASK: mask_r = v[3:0];
      default: ;
    endcase
  endfunction

  // A byte at frame start either opens a frame or is dropped as a bad type.
  function automatic void start_frame(logic [7:0] b);
    int plen;
    plen = 0;
    if (b < pd_pkg::NUM_TYPES_DEF) plen = len_tab[b[1:0]];
    if (plen >= 1 && plen <= pd_pkg::MAX_PAYLOAD_DEF) begin
      frame_buf[0] = b;
      crc_acc      = crc_byte(init_r, b, poly_r);
      want         = plen + pd_pkg::OVERHEAD;
      got          = 1;
    end else begin
      got = 0;
      note(pd_pkg::EV_BAD_TYPE, b, 8'd0, 6'd0);
    end
  endfunction

  // Works out every beat that one accepted byte causes and queues them.
  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] ty;
    fresh_beats.delete();
    if (got == 0) begin
      start_frame(b);
    end else if (got == 1) begin
      if (b != want) begin
        // The length byte does not fit the type: drop the type byte and
        // give the length byte a second chance as a type.
        note(pd_pkg::EV_LEN_MISMATCH, frame_buf[0], 8'd0, 6'd0);
        start_frame(b);
      end else begin
        frame_buf[1] = b;
        crc_acc      = crc_byte(crc_acc, b, poly_r);
        got          = 2;
      end
    end else begin
      if (got < STORE_DEPTH) frame_buf[got] = b;
      crc_acc = crc_byte(crc_acc, b, poly_r);
      got++;
      if (got >= want || got >= STORE_DEPTH) begin
        ty = frame_buf[0];
        if (crc_acc != 16'd0) begin
          note(pd_pkg::EV_CRC_FAIL, ty, 8'd0, 6'd0);
        end else if (ty < pd_pkg::NUM_TYPES_DEF && mask_r[ty[1:0]]) begin
          for (int i = 0; i < int'(want) - pd_pkg::OVERHEAD &&
               i + pd_pkg::HDR_BYTES < STORE_DEPTH; i++) begin
            note(pd_pkg::EV_PAYLOAD, ty, frame_buf[i + pd_pkg::HDR_BYTES], i[5:0]);
          end
        end
        got = 0;
      end
    end
    if (fresh_beats.size() > 0) fresh_beats[fresh_beats.size() - 1].last = 1'b1;
    foreach (fresh_beats[i]) expected_beats.push_back(fresh_beats[i]);
  endfunction

  // -------------------------------------------------------------------------
  // Output side: random backpressure and the beat checker.
  // -------------------------------------------------------------------------

  // Ready drops at random in bursts; once the run turns calm it
  // stays high for good.
  initial begin
    int stall_left;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm) begin
        out_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int seen, input int wanted);
    if (seen != wanted) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, seen, wanted));
    end
  endtask

  // Every beat taken from the block is matched against the oldest beat the
  // predictor owes. Signals are sampled at the edge, before any update of it.
  initial begin
    result_beat_t rb;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("beat with nothing expected (event %0d, type %0d)",
                                    out_bus.event_res, out_bus.frame_type));
        end else begin
          rb = expected_beats.pop_front();
          check_field("event_res", out_bus.event_res, rb.ev);
          check_field("frame_type", out_bus.frame_type, rb.ty);
          check_field("payload_byte", out_bus.payload_byte, rb.data);
          check_field("byte_index", out_bus.byte_index, rb.idx);
          check_field("last", out_bus.last, rb.last);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Input side and configuration.
  // -------------------------------------------------------------------------

  // Sends one byte, with an occasional gap ahead of it, and waits for the
  // handshake. Valid is left high so the next byte can follow back to back.
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    deframe_byte(b);
    items_sent++;
  endtask

  // Builds and sends a whole frame. The CRC is made with the current
  // registers so the check over the full frame lands on zero, unless it is
  // spoiled on purpose. A negative fill gives random payload.
  task automatic send_frame(input logic [7:0] ty, input int plen, input logic [7:0] len_byte,
                            input bit spoil, input int fill);
    logic [7:0]  fb[$];
    logic [15:0] c;
    fb.push_back(ty);
    fb.push_back(len_byte);
    for (int i = 0; i < plen; i++) begin
      fb.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : fill[7:0]);
    end
    c = init_r;
    foreach (fb[i]) c = crc_byte(c, fb[i], poly_r);
    if (spoil) c ^= 16'($urandom_range(1, 65535));
    fb.push_back(c[15:8]);
    fb.push_back(c[7:0]);
    foreach (fb[i]) send_byte(fb[i]);
  endtask

  // Lowers valid, waits for every owed beat, then lets the block finish any
  // byte still in its CRC unit. Only after this may registers change.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The enable is left high across a series of writes and lowered by the
  // caller once the series is done.
  task automatic cfg_write(input logic [pd_pkg::CFG_IW-1:0] idx,
                           input logic [pd_pkg::CFG_DW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    model_write(idx, v);
  endtask

  // Writes every register, with junk in the bits above each register's
  // width, and pokes the unused index as well.
  task automatic apply_setting(input logic [7:0] l0, input logic [7:0] l1,
                               input logic [7:0] l2, input logic [7:0] l3,
                               input logic [15:0] poly, input logic [15:0] init,
                               input logic [3:0] mask);
    cfg_write(pd_pkg::REG_LEN0, {8'($urandom), l0});
    cfg_write(pd_pkg::REG_LEN1, {8'($urandom), l1});
    cfg_write(pd_pkg::REG_LEN2, {8'($urandom), l2});
    cfg_write(pd_pkg::REG_LEN3, {8'($urandom), l3});
    cfg_write(pd_pkg::REG_POLY, poly);
    cfg_write(pd_pkg::REG_INIT, init);
    cfg_write(pd_pkg::REG_MASK, {12'($urandom), mask});
    cfg_write(REG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Tests.
  // -------------------------------------------------------------------------

  // Out of reset every payload length is zero, so any byte is a bad type,
  // including the lowest and highest byte values.
  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_idle();
  endtask

  // Type 0 gets the shortest payload and type 1 the longest; type 2 is one
  // past the limit and type 3 gets three; every length has junk above its eight
  // bits. Types 2 and 3 are disabled in the mask.
  task automatic test_register_setup();
    apply_setting(8'd1, 8'(pd_pkg::MAX_PAYLOAD_DEF), 8'(pd_pkg::MAX_PAYLOAD_DEF + 1), 8'd3,
                  pd_pkg::CRC_POLY_RST, pd_pkg::CRC_INIT_RST, 4'h3);
  endtask

  task automatic test_short_frame();
    send_frame(8'd0, 1, 8'(1 + pd_pkg::OVERHEAD), 1'b0, 8'hFF);
    wait_idle();
  endtask

  // A length byte that is itself a type with an illegal length: one input
  // byte causes a length mismatch and then a bad type.
  task automatic test_length_mismatch();
    send_byte(8'd0);
    send_byte(8'd2);
    wait_idle();
  endtask

  // The mismatching length byte opens a frame of type 3, which is good but
  // disabled, so the whole frame stays silent after the mismatch beat.
  task automatic test_disabled_type();
    send_byte(8'd0);
    send_frame(8'd3, 3, 8'(3 + pd_pkg::OVERHEAD), 1'b0, -1);
    wait_idle();
  endtask

  task automatic test_crc_failure();
    send_frame(8'd0, 1, 8'(1 + pd_pkg::OVERHEAD), 1'b1, 8'h00);
    wait_idle();
  endtask

  // Polynomial and seed change halfway through a frame. The frame keeps the
  // CRC gathered so far, and the CRC bytes sent after the change are that
  // running value, which clears under any polynomial.
  task automatic test_crc_change_midframe();
    logic [15:0] held;
    send_byte(8'd0);
    send_byte(8'(1 + pd_pkg::OVERHEAD));
    send_byte(8'($urandom_range(0, 255)));
    wait_idle();
    cfg_write(pd_pkg::REG_POLY, 16'h8005);
    cfg_write(pd_pkg::REG_INIT, 16'h0000);
    cfg_we <= 1'b0;
    @(posedge clk);
    held = crc_acc;
    send_byte(held[15:8]);
    send_byte(held[7:0]);
    wait_idle();
  endtask

  // Mostly well-formed frames with random content, plus spoiled CRCs, wrong
  // length bytes and loose noise bytes. Long payloads are used sparingly.
  task automatic test_random_phase(input int quota);
    int         first;
    int         pick;
    int         plen;
    logic [7:0] ty;
    logic [7:0] lb;
    first = items_sent;
    while (items_sent - first < quota) begin
      pick = $urandom_range(0, 9);
      ty   = 8'($urandom_range(0, 3));
      if (len_tab[ty[1:0]] > 8 && $urandom_range(0, 3) != 0) ty = ty ^ 8'd1;
      plen = len_tab[ty[1:0]];
      if (plen < 1 || plen > pd_pkg::MAX_PAYLOAD_DEF) plen = $urandom_range(1, 4);
      if (pick <= 5) begin
        send_frame(ty, plen, 8'(plen + pd_pkg::OVERHEAD), 1'b0, -1);
      end else if (pick == 6) begin
        send_frame(ty, plen, 8'(plen + pd_pkg::OVERHEAD), 1'b1, -1);
      end else if (pick == 7) begin
        lb = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        if (lb == plen + pd_pkg::OVERHEAD) lb ^= 8'h80;
        send_frame(ty, plen, lb, 1'b0, -1);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    wait_idle();
  endtask

  // -------------------------------------------------------------------------
  // Sequence.
  // -------------------------------------------------------------------------
  initial begin
    errors     = 0;
    items_sent = 0;
    calm       = 1'b0;
    model_reset();
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    in_bus.valid   <= 1'b0;
    in_bus.rx_byte <= 8'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_setup();
    test_short_frame();
    test_length_mismatch();
    test_disabled_type();
    test_crc_failure();
    test_crc_change_midframe();

    // Common polynomial and seed, all types short and enabled.
    apply_setting(8'd2, 8'd5, 8'd1, 8'd4, pd_pkg::CRC_POLY_RST, pd_pkg::CRC_INIT_RST, 4'hF);
    test_random_phase(32);

    // All-ones polynomial, zero seed, the longest payload on type 0 and an
    // unusable length on type 2.
    apply_setting(8'(pd_pkg::MAX_PAYLOAD_DEF), 8'd3, 8'hFF, 8'd6, 16'hFFFF, 16'h0000, 4'hB);
    test_random_phase(32);

    // Zero polynomial and nothing enabled: only error beats come out.
    apply_setting(8'($urandom_range(1, 6)), 8'd0, 8'($urandom_range(1, 6)),
                  8'(pd_pkg::MAX_PAYLOAD_DEF - 1), 16'h0000, 16'($urandom), 4'h0);
    test_random_phase(32);

    // Last stretch runs with no gaps and no backpressure.
    apply_setting(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                  8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                  16'($urandom), 16'($urandom), 4'hF);
    calm = 1'b1;
    test_random_phase(32);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
